// File: sv/arc_pkg.sv
// Shared types and constants for the audio rate converter.
// Depends on nothing; every other file of the block refers to it by scoped names.
package arc_pkg;

  // Fixed field widths and rate limits.
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned RATE_W      = 18;
  localparam int unsigned TARGET_RATE = 16000;
  localparam int unsigned MIN_RATE    = 4000;
  localparam int unsigned MAX_GROUP   = 15;

  // Internal widths.
  localparam int unsigned GRP_W   = 4;   // group size, 1 to 15
  localparam int unsigned ACC_W   = 20;  // sum of up to 15 samples
  localparam int unsigned DIFF_W  = SAMPLE_W + 1;
  localparam int unsigned PHASE_W = 19;  // phase stays below TARGET_RATE + 2^RATE_W
  localparam int unsigned MB_W    = $clog2(TARGET_RATE);      // any phase below target
  localparam int unsigned ADD_W   = $clog2(TARGET_RATE + 1);  // rounding addend
  localparam int unsigned NUM_W   = 32;  // rounded numerator, signed
  localparam int unsigned RECIP_W = 32;
  localparam int unsigned PROD_W  = 64;
  localparam int unsigned Q_W     = 18;
  localparam int unsigned RES_W   = Q_W + 1;

  // Constant division by reciprocal multiplication. The reciprocals are rounded up,
  // which makes the truncated quotient exact for every numerator the datapath forms.
  localparam int unsigned GRP_SHIFT    = 33;
  localparam int unsigned INTERP_SHIFT = 46;
  localparam logic [RECIP_W-1:0] INTERP_RECIP =
    RECIP_W'(((64'd1 << INTERP_SHIFT) + 64'(2 * TARGET_RATE) - 64'd1)
             / 64'(2 * TARGET_RATE));

  // Reciprocal of twice the group size, indexed by group size. Sizes 0 and 1 never average.
  localparam logic [RECIP_W-1:0] GRP_RECIP [16] = '{
    RECIP_W'(0),
    RECIP_W'(0),
    RECIP_W'(((64'd1 << GRP_SHIFT) + 64'd3)  / 64'd4),
    RECIP_W'(((64'd1 << GRP_SHIFT) + 64'd5)  / 64'd6),
    RECIP_W'(((64'd1 << GRP_SHIFT) + 64'd7)  / 64'd8),
    RECIP_W'(((64'd1 << GRP_SHIFT) + 64'd9)  / 64'd10),
    RECIP_W'(((64'd1 << GRP_SHIFT) + 64'd11) / 64'd12),
    RECIP_W'(((64'd1 << GRP_SHIFT) + 64'd13) / 64'd14),
    RECIP_W'(((64'd1 << GRP_SHIFT) + 64'd15) / 64'd16),
    RECIP_W'(((64'd1 << GRP_SHIFT) + 64'd17) / 64'd18),
    RECIP_W'(((64'd1 << GRP_SHIFT) + 64'd19) / 64'd20),
    RECIP_W'(((64'd1 << GRP_SHIFT) + 64'd21) / 64'd22),
    RECIP_W'(((64'd1 << GRP_SHIFT) + 64'd23) / 64'd24),
    RECIP_W'(((64'd1 << GRP_SHIFT) + 64'd25) / 64'd26),
    RECIP_W'(((64'd1 << GRP_SHIFT) + 64'd27) / 64'd28),
    RECIP_W'(((64'd1 << GRP_SHIFT) + 64'd29) / 64'd30)
  };

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_GROUP,
    MODE_INTERP
  } arc_mode_t;

  typedef enum logic [1:0] {
    CMD_PASS,
    CMD_AVG,
    CMD_RUN
  } arc_cmd_kind_t;

  // One classified item handed from the front to the back.
  typedef struct packed {
    arc_cmd_kind_t               kind;
    logic signed [ACC_W-1:0]     acc;
    logic signed [SAMPLE_W-1:0]  prev;
    logic signed [SAMPLE_W-1:0]  x;
    logic [GRP_W-1:0]            n;
  } arc_cmd_t;

  // Rate load from the configuration decode.
  typedef struct packed {
    logic              load;
    logic [RATE_W-1:0] eff;
  } arc_rate_t;

endpackage

// File: sv/arc_ifs.sv
// Valid/ready channel interfaces for samples, results and the rate register.
// Depends on arc_pkg for the payload widths.
interface arc_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [arc_pkg::SAMPLE_W-1:0]  in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink (input valid, input in_sample, output ready);
endinterface

interface arc_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [arc_pkg::SAMPLE_W-1:0]  out_sample;
  logic                                 last_of_run;

  modport source (output valid, output out_sample, output last_of_run, input ready);
  modport sink (input valid, input out_sample, input last_of_run, output ready);
endinterface

interface arc_rate_if;
  logic                          valid;
  logic                          ready;
  logic [arc_pkg::RATE_W-1:0]    source_rate;

  modport source (output valid, output source_rate, input ready);
  modport sink (input valid, input source_rate, output ready);
endinterface

// File: sv/arc_front.sv
// Front part: decodes the rate register, accepts samples and classifies them into commands.
// Depends on arc_pkg and the channel interfaces in arc_ifs.sv.
module arc_front (
  input  logic               clk,
  input  logic               rst,
  arc_sample_if.sink         samples,
  arc_rate_if.sink           rate_cfg,
  input  logic               q_full,
  output logic               push,
  output arc_pkg::arc_cmd_t  cmd,
  output arc_pkg::arc_rate_t rate
);

  localparam int unsigned RATE_W   = arc_pkg::RATE_W;
  localparam int unsigned GRP_W    = arc_pkg::GRP_W;
  localparam int unsigned ACC_W    = arc_pkg::ACC_W;
  localparam int unsigned SAMPLE_W = arc_pkg::SAMPLE_W;

  arc_pkg::arc_mode_t         mode;
  arc_pkg::arc_mode_t         mode_new;
  logic [GRP_W-1:0]           group_size;
  logic [GRP_W-1:0]           size_new;
  logic [GRP_W-1:0]           multiple;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    acc_sum;
  logic [GRP_W-1:0]           fill;
  logic [GRP_W-1:0]           fill_inc;
  logic signed [SAMPLE_W-1:0] prev;
  logic                       primed;
  logic [RATE_W-1:0]          eff;
  logic                       accept;
  logic                       group_done;

  assign rate_cfg.ready = 1'b1;
  assign samples.ready  = !q_full;
  assign accept         = samples.valid && samples.ready;

  // Rate decode: zero means the target rate, low rates are clamped, and a whole
  // multiple of the target up to fifteen selects group averaging.
  always_comb begin
    eff = rate_cfg.source_rate;
    if (eff == '0) begin
      eff = RATE_W'(arc_pkg::TARGET_RATE);
    end
    if (eff < RATE_W'(arc_pkg::MIN_RATE)) begin
      eff = RATE_W'(arc_pkg::MIN_RATE);
    end
    multiple = '0;
    for (int k = 2; k <= int'(arc_pkg::MAX_GROUP); k++) begin
      if (eff == RATE_W'(k * arc_pkg::TARGET_RATE)) begin
        multiple = GRP_W'(k);
      end
    end
    if (eff == RATE_W'(arc_pkg::TARGET_RATE)) begin
      mode_new = arc_pkg::MODE_PASS;
      size_new = GRP_W'(1);
    end else if (multiple != '0) begin
      mode_new = arc_pkg::MODE_GROUP;
      size_new = multiple;
    end else begin
      mode_new = arc_pkg::MODE_INTERP;
      size_new = GRP_W'(1);
    end
  end

  assign rate.load = rate_cfg.valid && rate_cfg.ready;
  assign rate.eff  = eff;

  assign acc_sum    = acc + ACC_W'(samples.in_sample);
  assign fill_inc   = fill + GRP_W'(1);
  assign group_done = fill_inc >= group_size;

  always_comb begin
    cmd.kind = arc_pkg::CMD_PASS;
    cmd.acc  = acc_sum;
    cmd.prev = prev;
    cmd.x    = samples.in_sample;
    cmd.n    = group_size;
    push     = 1'b0;
    case (mode)
      arc_pkg::MODE_PASS: begin
        push = accept;
      end
      arc_pkg::MODE_GROUP: begin
        cmd.kind = arc_pkg::CMD_AVG;
        push     = accept && group_done;
      end
      arc_pkg::MODE_INTERP: begin
        // The very first sample only primes the previous value.
        cmd.kind = arc_pkg::CMD_RUN;
        push     = accept && primed;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= arc_pkg::MODE_PASS;
      group_size <= GRP_W'(1);
      acc        <= '0;
      fill       <= '0;
      prev       <= '0;
      primed     <= 1'b0;
    end else if (rate.load) begin
      mode       <= mode_new;
      group_size <= size_new;
      acc        <= '0;
      fill       <= '0;
      prev       <= '0;
      primed     <= 1'b0;
    end else if (accept) begin
      case (mode)
        arc_pkg::MODE_GROUP: begin
          if (group_done) begin
            acc  <= '0;
            fill <= '0;
          end else begin
            acc  <= acc_sum;
            fill <= fill_inc;
          end
        end
        arc_pkg::MODE_INTERP: begin
          prev   <= samples.in_sample;
          primed <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: sv/arc_cmd_queue.sv
// Short command queue between the front and the back of the rate converter.
// Depends on arc_pkg for the command type and the queue depth.
module arc_cmd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  arc_pkg::arc_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output arc_pkg::arc_cmd_t head
);

  localparam int unsigned QPTR_W = arc_pkg::QPTR_W;
  localparam int unsigned CNT_W  = QPTR_W + 1;

  arc_pkg::arc_cmd_t slots [arc_pkg::QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full       = count == CNT_W'(arc_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: sv/arc_back.sv
// Back part: steps the interpolation phase and runs the shared rounding divider pipeline.
// Depends on arc_pkg and the result channel interface in arc_ifs.sv.
module arc_back #(
  parameter int unsigned MAX_OUTPUTS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  arc_pkg::arc_cmd_t  head,
  output logic               pop,
  input  arc_pkg::arc_rate_t rate,
  arc_result_if.source       results
);

  localparam int unsigned RATE_W   = arc_pkg::RATE_W;
  localparam int unsigned SAMPLE_W = arc_pkg::SAMPLE_W;
  localparam int unsigned ACC_W    = arc_pkg::ACC_W;
  localparam int unsigned DIFF_W   = arc_pkg::DIFF_W;
  localparam int unsigned PHASE_W  = arc_pkg::PHASE_W;
  localparam int unsigned MB_W     = arc_pkg::MB_W;
  localparam int unsigned ADD_W    = arc_pkg::ADD_W;
  localparam int unsigned NUM_W    = arc_pkg::NUM_W;
  localparam int unsigned RECIP_W  = arc_pkg::RECIP_W;
  localparam int unsigned PROD_W   = arc_pkg::PROD_W;
  localparam int unsigned Q_W      = arc_pkg::Q_W;
  localparam int unsigned RES_W    = arc_pkg::RES_W;
  localparam int unsigned MADE_W   = $clog2(MAX_OUTPUTS + 1);

  localparam logic [MADE_W-1:0]  MADE_CAP  = MADE_W'(MAX_OUTPUTS);
  localparam logic [MADE_W-1:0]  MADE_LAST = MADE_W'(MAX_OUTPUTS - 1);
  localparam logic [PHASE_W-1:0] PH_TARGET = PHASE_W'(arc_pkg::TARGET_RATE);

  // Sequencer state.
  logic [RATE_W-1:0]          eff;
  logic [PHASE_W-1:0]         phase;
  logic [PHASE_W-1:0]         phase_next;
  logic [PHASE_W-1:0]         phase_sum;
  logic [MADE_W-1:0]          made;
  logic [MADE_W-1:0]          made_next;
  logic                       in_window;
  logic                       issue;
  logic                       adv;
  logic signed [DIFF_W-1:0]   diff;

  // Job being issued.
  logic signed [ACC_W-1:0]    j_a;
  logic [MB_W-1:0]            j_b;
  logic [ADD_W-1:0]           j_add;
  logic [RECIP_W-1:0]         j_recip;
  logic                       j_grp;
  logic signed [SAMPLE_W-1:0] j_base;
  logic                       j_last;

  // Pipeline registers.
  logic                       s0_valid;
  logic signed [ACC_W-1:0]    s0_a;
  logic [MB_W-1:0]            s0_b;
  logic [ADD_W-1:0]           s0_add;
  logic [RECIP_W-1:0]         s0_recip;
  logic                       s0_grp;
  logic signed [SAMPLE_W-1:0] s0_base;
  logic                       s0_last;
  logic                       s1_valid;
  logic [NUM_W-1:0]           s1_num;
  logic [RECIP_W-1:0]         s1_recip;
  logic                       s1_grp;
  logic signed [SAMPLE_W-1:0] s1_base;
  logic                       s1_last;
  logic                       s2_valid;
  logic [PROD_W-1:0]          s2_prod;
  logic                       s2_neg;
  logic                       s2_grp;
  logic signed [SAMPLE_W-1:0] s2_base;
  logic                       s2_last;
  logic                       out_valid;
  logic [SAMPLE_W-1:0]        out_sample_r;
  logic                       out_last;

  // Stage datapath.
  logic signed [ACC_W+MB_W:0] mul1;
  logic [NUM_W-1:0]           num;
  logic                       neg;
  logic [NUM_W-2:0]           mag;
  logic [PROD_W-1:0]          prod;
  logic [Q_W-1:0]             quo;
  logic [RES_W-1:0]           quo_s;
  logic [RES_W-1:0]           res;

  assign adv       = !out_valid || results.ready;
  assign phase_sum = phase + PHASE_W'(eff);
  assign in_window = phase < PH_TARGET;
  assign diff      = DIFF_W'(head.x) - DIFF_W'(head.prev);

  always_comb begin
    j_a     = '0;
    j_b     = '0;
    j_add   = ADD_W'(arc_pkg::TARGET_RATE);
    j_recip = arc_pkg::INTERP_RECIP;
    j_grp   = 1'b0;
    j_base  = head.x;
    j_last  = 1'b1;
    case (head.kind)
      arc_pkg::CMD_AVG: begin
        j_a     = head.acc;
        j_b     = MB_W'(1);
        j_add   = ADD_W'(head.n);
        j_recip = arc_pkg::GRP_RECIP[head.n];
        j_grp   = 1'b1;
        j_base  = '0;
      end
      arc_pkg::CMD_RUN: begin
        j_a    = ACC_W'(diff);
        j_b    = phase[MB_W-1:0];
        j_base = head.prev;
        j_last = (phase_sum >= PH_TARGET) || (made == MADE_LAST);
      end
      default: begin
      end
    endcase
  end

  // One phase step per cycle unless stalled; steps past the cap still advance the phase.
  always_comb begin
    pop        = 1'b0;
    issue      = 1'b0;
    phase_next = phase;
    made_next  = made;
    if (adv && head_valid) begin
      case (head.kind)
        arc_pkg::CMD_RUN: begin
          if (in_window) begin
            issue      = made < MADE_CAP;
            phase_next = phase_sum;
            made_next  = made + MADE_W'(issue);
          end else begin
            phase_next = phase - PH_TARGET;
            made_next  = '0;
            pop        = 1'b1;
          end
        end
        default: begin
          issue = 1'b1;
          pop   = 1'b1;
        end
      endcase
    end
  end

  // Numerator 2*a*b + addend; the floor of a negative value is taken as the
  // complement of the floor of its complement.
  assign mul1  = s0_a * $signed({1'b0, s0_b});
  assign num   = {mul1[NUM_W-2:0], 1'b0} + NUM_W'(s0_add);
  assign neg   = s1_num[NUM_W-1];
  assign mag   = neg ? ~s1_num[NUM_W-2:0] : s1_num[NUM_W-2:0];
  assign prod  = mag * s1_recip;
  assign quo   = s2_grp ? s2_prod[arc_pkg::GRP_SHIFT +: Q_W]
                        : s2_prod[arc_pkg::INTERP_SHIFT +: Q_W];
  assign quo_s = s2_neg ? ~{1'b0, quo} : {1'b0, quo};
  assign res   = RES_W'(s2_base) + quo_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      eff       <= RATE_W'(arc_pkg::TARGET_RATE);
      phase     <= '0;
      made      <= '0;
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rate.load) begin
        eff   <= rate.eff;
        phase <= '0;
        made  <= '0;
      end else begin
        phase <= phase_next;
        made  <= made_next;
      end
      if (adv) begin
        s0_valid  <= issue;
        s1_valid  <= s0_valid;
        s2_valid  <= s1_valid;
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_a         <= j_a;
      s0_b         <= j_b;
      s0_add       <= j_add;
      s0_recip     <= j_recip;
      s0_grp       <= j_grp;
      s0_base      <= j_base;
      s0_last      <= j_last;
      s1_num       <= num;
      s1_recip     <= s0_recip;
      s1_grp       <= s0_grp;
      s1_base      <= s0_base;
      s1_last      <= s0_last;
      s2_prod      <= prod;
      s2_neg       <= neg;
      s2_grp       <= s1_grp;
      s2_base      <= s1_base;
      s2_last      <= s1_last;
      out_sample_r <= res[SAMPLE_W-1:0];
      out_last     <= s2_last;
    end
  end

  assign results.valid       = out_valid;
  assign results.out_sample  = out_sample_r;
  assign results.last_of_run = out_last;

  a_made_cap : assert property (@(posedge clk) disable iff (rst)
    made <= MADE_CAP)
    else $error("output count for one sample exceeds the cap");

  a_cap_stops_issue : assert property (@(posedge clk) disable iff (rst)
    (head_valid && head.kind == arc_pkg::CMD_RUN && made == MADE_CAP) |-> !issue)
    else $error("job issued beyond the output cap");

  a_phase_after_run : assert property (@(posedge clk) disable iff (rst)
    (pop && head.kind == arc_pkg::CMD_RUN) |=> (phase < PHASE_W'(eff)))
    else $error("phase left at or above the step after a sample");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !results.ready) |=> ($stable(s2_prod) && $stable(s2_valid)))
    else $error("pipeline moved while the result was stalled");

endmodule

// File: sv/audio_rate_converter_unit.sv
// Top level of the audio rate converter: front, command queue and back.
// Depends on arc_pkg, arc_ifs.sv, arc_front, arc_cmd_queue and arc_back.
//
//   Channel    Direction  Payload                      Moves
//   samples    in         in_sample (16 b signed)      one source sample per item
//   results    out        out_sample, last_of_run      one converted sample per item
//   rate_cfg   in         source_rate (18 b unsigned)  one rate register write
//
// Cycles: the front takes one sample per cycle while the four-entry command queue has room.
// The back takes a passthrough or averaging command off the queue head as it issues the job;
// an interpolation run issues a job per in-window phase step up to the cap, then pops.
// Each result goes through the s0, s1 and s2 registers of the shared divider to the output.
// Reset clears all carried state and loads a source rate of 16000 (passthrough).
// A result stall freezes the back only; the front keeps accepting until the queue fills.

module audio_rate_converter_unit #(
  parameter int unsigned MAX_OUTPUTS_PER_SAMPLE = 4
) (
  input  logic          clk,
  input  logic          rst,
  arc_sample_if.sink    samples,
  arc_result_if.source  results,
  arc_rate_if.sink      rate_cfg
);

  // Classified commands travel from the front to the back through the queue.
  logic               q_full;
  logic               push;
  logic               pop;
  logic               head_valid;
  arc_pkg::arc_cmd_t  push_cmd;
  arc_pkg::arc_cmd_t  head;

  // A rate write clears the front's group and priming state and reloads the
  // back's phase step, so both halves start the new mode together.
  arc_pkg::arc_rate_t rate;

  // The front owns the mode: passthrough and full groups become one-result
  // commands, interpolation samples become runs that carry the previous sample.
  arc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples),
    .rate_cfg (rate_cfg),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd),
    .rate     (rate)
  );

  arc_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // The back owns the interpolation phase. A run command stays at the queue head
  // until its phase steps are done, and is popped on the closing cycle.
  arc_back #(
    .MAX_OUTPUTS (MAX_OUTPUTS_PER_SAMPLE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .rate       (rate),
    .results    (results)
  );

endmodule

// File: tb/sv/arc_result_checker.sv
`timescale 1ns / 100ps
// Checker for the audio rate converter: watches the sample, result and rate channels.
// Predicts converted samples and compares them in order. Depends on arc_pkg.
module arc_result_checker #(
  parameter int MAX_OUTPUTS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  input  logic                                sample_ready,
  input  logic signed [arc_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                result_valid,
  input  logic                                result_ready,
  input  logic signed [arc_pkg::SAMPLE_W-1:0] out_sample,
  input  logic                                last_of_run,
  input  logic                                rate_valid,
  input  logic                                rate_ready,
  input  logic [arc_pkg::RATE_W-1:0]          source_rate,
  output int                                  mismatch_count,
  output int                                  expected_left
);

  localparam longint TARGET = arc_pkg::TARGET_RATE;

  typedef struct packed {
    logic signed [arc_pkg::SAMPLE_W-1:0] out_value;
    logic                                run_end;
  } conv_out_t;

  conv_out_t expected_q[$];

  // Copy of the converter's carried state.
  arc_pkg::arc_mode_t                  mode;
  logic [arc_pkg::GRP_W-1:0]           grp_size;
  logic [arc_pkg::GRP_W-1:0]           grp_fill;
  logic signed [arc_pkg::ACC_W-1:0]    grp_sum;
  logic [arc_pkg::PHASE_W-1:0]         phase;
  logic signed [arc_pkg::SAMPLE_W-1:0] prev_sample;
  logic                                primed;
  logic [arc_pkg::RATE_W-1:0]          eff_rate;

  function automatic longint floor_div(input longint num, input longint den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  // A rate write picks the mode and clears everything carried.
  function automatic void load_rate(input logic [arc_pkg::RATE_W-1:0] r);
    logic [arc_pkg::RATE_W-1:0] eff;
    eff = r;
    if (eff == 0) eff = arc_pkg::RATE_W'(arc_pkg::TARGET_RATE);
    if (eff < arc_pkg::MIN_RATE) eff = arc_pkg::RATE_W'(arc_pkg::MIN_RATE);
    eff_rate    = eff;
    grp_sum     = '0;
    grp_fill    = '0;
    phase       = '0;
    prev_sample = '0;
    primed      = 1'b0;
    grp_size    = arc_pkg::GRP_W'(1);
    if (eff == arc_pkg::TARGET_RATE) begin
      mode = arc_pkg::MODE_PASS;
    end else if ((eff % arc_pkg::TARGET_RATE) == 0 &&
                 (eff / arc_pkg::TARGET_RATE) <= arc_pkg::MAX_GROUP) begin
      mode     = arc_pkg::MODE_GROUP;
      grp_size = arc_pkg::GRP_W'(eff / arc_pkg::TARGET_RATE);
    end else begin
      mode = arc_pkg::MODE_INTERP;
    end
  endfunction

  function automatic void predict_conversion(input logic signed [arc_pkg::SAMPLE_W-1:0] x);
    logic signed [arc_pkg::SAMPLE_W-1:0] vals [MAX_OUTPUTS];
    int     made;
    longint n;
    longint diff;
    longint num;
    made = 0;
    case (mode)
      arc_pkg::MODE_PASS: begin
        vals[0] = x;
        made    = 1;
      end
      arc_pkg::MODE_GROUP: begin
        grp_sum  = grp_sum + x;
        grp_fill = grp_fill + 1'b1;
        if (grp_fill >= grp_size) begin
          n        = longint'(grp_size);
          vals[0]  = arc_pkg::SAMPLE_W'(floor_div(2 * longint'(grp_sum) + n, 2 * n));
          made     = 1;
          grp_sum  = '0;
          grp_fill = '0;
        end
      end
      default: begin
        if (!primed) begin
          prev_sample = x;
          phase       = arc_pkg::PHASE_W'(arc_pkg::TARGET_RATE);
          primed      = 1'b1;
        end
        while (phase < arc_pkg::TARGET_RATE) begin
          // Outputs past the per-sample cap are lost but the phase still moves.
          if (made < MAX_OUTPUTS) begin
            diff       = longint'(x) - longint'(prev_sample);
            num        = 2 * diff * longint'(phase) + TARGET;
            vals[made] = arc_pkg::SAMPLE_W'(longint'(prev_sample) +
                                            floor_div(num, 2 * TARGET));
            made++;
          end
          phase = phase + eff_rate;
        end
        phase       = phase - arc_pkg::PHASE_W'(arc_pkg::TARGET_RATE);
        prev_sample = x;
      end
    endcase
    for (int i = 0; i < made; i++)
      expected_q.push_back('{out_value: vals[i], run_end: (i == made - 1)});
  endfunction

  always @(posedge clk) begin
    conv_out_t want;
    if (rst) begin
      load_rate(arc_pkg::RATE_W'(arc_pkg::TARGET_RATE));
      expected_q.delete();
      mismatch_count <= 0;
    end else begin
      if (rate_valid && rate_ready) load_rate(source_rate);
      if (result_valid && result_ready) begin
        if (expected_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected result: sample %0d last %0b",
                     $time, out_sample, last_of_run);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.out_value !== out_sample || want.run_end !== last_of_run) begin
            if (mismatch_count < 10)
              $display("%0t: result mismatch: expected sample %0d last %0b, got %0d last %0b",
                       $time, want.out_value, want.run_end, out_sample, last_of_run);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (sample_valid && sample_ready) predict_conversion(in_sample);
    end
    expected_left <= expected_q.size();
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Top of the audio rate converter testbench: clock, reset, sample and rate stimulus.
// Depends on arc_pkg, arc_ifs.sv, audio_rate_converter_unit and arc_result_checker.
module tb_top;

  // Quiet cycles allowed before the run is declared hung. The slowest correct run
  // has result stalls where the ready style is redrawn, gaps between sender bursts
  // and the drain pause around each rate write, so this leaves a wide margin.
  localparam int QUIET_LIMIT = 2000;
  // Cycles let pass before a rate write once no result is owed. Priming and part-built
  // groups never reach the queue; what may remain are up to four queued runs that
  // make no output, each popped on its closing step.
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 280;

  typedef enum {
    READY_ALWAYS,
    READY_PATTERN,
    READY_SPARSE
  } ready_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  arc_sample_if samples_if ();
  arc_result_if results_if ();
  arc_rate_if   rate_if ();

  int mismatch_count;
  int expected_left;
  int quiet_cycles;
  int burst_left;

  always #5 clk = ~clk;

  audio_rate_converter_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples_if),
    .results  (results_if),
    .rate_cfg (rate_if)
  );

  arc_result_checker #(
    .MAX_OUTPUTS (4)
  ) i_checker (
    .clk            (clk),
    .rst            (rst),
    .sample_valid   (samples_if.valid),
    .sample_ready   (samples_if.ready),
    .in_sample      (samples_if.in_sample),
    .result_valid   (results_if.valid),
    .result_ready   (results_if.ready),
    .out_sample     (results_if.out_sample),
    .last_of_run    (results_if.last_of_run),
    .rate_valid     (rate_if.valid),
    .rate_ready     (rate_if.ready),
    .source_rate    (rate_if.source_rate),
    .mismatch_count (mismatch_count),
    .expected_left  (expected_left)
  );

  // Offers one sample and holds it until the block takes it. The sender runs in
  // bursts; when a burst is used up, valid drops for a random gap first. Within a
  // burst valid stays high from one item to the next.
  task automatic push_sample(input logic signed [arc_pkg::SAMPLE_W-1:0] s);
    if (burst_left == 0) begin
      @(negedge clk) samples_if.valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      // Now and then a long burst so the queue gets pushed to full.
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
    end
    @(negedge clk);
    samples_if.valid     = 1'b1;
    samples_if.in_sample = s;
    do @(posedge clk); while (!samples_if.ready);
    burst_left--;
  endtask

  task automatic end_phase();
    @(negedge clk) samples_if.valid = 1'b0;
    burst_left = 0;
  endtask

  // Rate writes happen only with the block idle: every owed result has come back,
  // and then the drain pause covers work that produces no result.
  task automatic set_rate(input logic [arc_pkg::RATE_W-1:0] r);
    end_phase();
    while (expected_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    rate_if.valid       = 1'b1;
    rate_if.source_rate = r;
    do @(posedge clk); while (!rate_if.ready);
    @(negedge clk) rate_if.valid = 1'b0;
  endtask

  // Result side: ready follows a style that is redrawn periodically. Always ready,
  // a repeating random 16-bit pattern, or one with a single ready bit.
  initial begin
    int unsigned  cyc;
    logic [15:0]  pattern;
    ready_style_t style;
    cyc              = 0;
    pattern          = '1;
    style            = READY_ALWAYS;
    results_if.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (cyc % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       style = READY_ALWAYS;
          1:       style = READY_PATTERN;
          default: style = READY_SPARSE;
        endcase
        if (style == READY_SPARSE) pattern = 16'h0001 << $urandom_range(0, 15);
        else                       pattern = 16'($urandom) | 16'h0001;
      end
      results_if.ready = (style == READY_ALWAYS) ? 1'b1 : pattern[cyc % 16];
      cyc++;
    end
  end

  // Watchdog: any handshake on any channel resets the count of quiet cycles.
  always @(posedge clk) begin
    if (rst || (samples_if.valid && samples_if.ready) ||
        (results_if.valid && results_if.ready) || (rate_if.valid && rate_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    int                                  sent;
    int                                  phase_no;
    int                                  count;
    logic [arc_pkg::RATE_W-1:0]          r;
    logic signed [arc_pkg::SAMPLE_W-1:0] s;
    logic [arc_pkg::RATE_W-1:0]          usual_rates [6];
    usual_rates = '{18'd8000, 18'd11025, 18'd22050, 18'd44100, 18'd48000, 18'd96000};

    samples_if.valid     = 1'b0;
    samples_if.in_sample = '0;
    rate_if.valid        = 1'b0;
    rate_if.source_rate  = '0;
    burst_left           = 0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // Directed part. Reset leaves the block in passthrough: extremes and
    // alternating bit patterns go straight through.
    push_sample(16'sh8000);
    push_sample(16'sh7FFF);
    push_sample(16'sh0000);
    push_sample(16'shFFFF);
    push_sample(16'sh5555);
    push_sample(16'shAAAA);

    // Pairs averaged: full-scale sums, then a tie on each side of zero, which
    // must round upward.
    set_rate(18'd32000);
    push_sample(16'sh7FFF);
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);
    push_sample(16'sh8000);
    push_sample(16'shFFFF);
    push_sample(16'sh0000);
    push_sample(16'sh0001);
    push_sample(16'sh0002);

    // Lowest rate: the first item only primes, then a full-scale swing gives the
    // most outputs per item.
    set_rate(18'd4000);
    push_sample(16'sh8000);
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);

    // All-ones rate is not a whole multiple, so it interpolates and most items
    // give no output at all.
    set_rate(18'h3FFFF);
    push_sample(16'sh0064);
    push_sample(-16'sh0064);
    push_sample(16'sh7FFF);
    push_sample(16'sh0005);

    // A zero rate means the target rate, i.e. passthrough again.
    set_rate(18'd0);
    push_sample(16'sh0007);
    push_sample(-16'sh0007);

    // A nonzero rate below the floor behaves as the floor.
    set_rate(18'd1);
    push_sample(16'sh0001);
    push_sample(16'shFFFF);

    // Random part: a new rate per phase. The first phases pin down the multiple
    // that is too large to average, the largest group and a common rate.
    sent     = 0;
    phase_no = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase_no == 0) begin
        r = 18'(arc_pkg::TARGET_RATE * 16);
      end else if (phase_no == 1) begin
        r = 18'(arc_pkg::TARGET_RATE * arc_pkg::MAX_GROUP);
      end else if (phase_no == 2) begin
        r = 18'd44100;
      end else begin
        case ($urandom_range(0, 7))
          0:       r = 18'd0;
          1:       r = 18'(arc_pkg::TARGET_RATE);
          2:       r = 18'(arc_pkg::TARGET_RATE * $urandom_range(2, 16));
          3:       r = 18'($urandom_range(1, arc_pkg::MIN_RATE - 1));
          4:       r = 18'(arc_pkg::MIN_RATE);
          5:       r = 18'($urandom_range(arc_pkg::MIN_RATE + 1, 18'h3FFFF));
          6:       r = 18'($urandom_range(arc_pkg::MIN_RATE, 2 * arc_pkg::TARGET_RATE));
          default: r = usual_rates[$urandom_range(0, 5)];
        endcase
      end
      set_rate(r);
      // The largest group needs many items per output.
      count = (phase_no == 1) ? 48 : $urandom_range(10, 40);
      for (int i = 0; i < count; i++) begin
        case ($urandom_range(0, 9))
          0:       s = 16'sh8000;
          1:       s = 16'sh7FFF;
          2:       s = 16'($signed($urandom_range(0, 64)) - 32);
          3:       s = -16'sh0001;
          default: s = 16'($urandom);
        endcase
        push_sample(s);
        sent++;
      end
      phase_no++;
    end

    end_phase();
    while (expected_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_left == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/arc_pkg.sv
sv/arc_ifs.sv
sv/arc_front.sv
sv/arc_cmd_queue.sv
sv/arc_back.sv
sv/audio_rate_converter_unit.sv
tb/sv/arc_result_checker.sv
tb/sv/tb_top.sv
